>>> src/mso_pkg.sv
// ----------------------------------------------------------------------------
// mso_pkg
// Shared types and constants for the marquee scroll offset block.
// ----------------------------------------------------------------------------
package mso_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int TIME_W            = 24;
  localparam int TICK_W            = 16;
  localparam int LEN_W             = 12;
  localparam int OFS_W             = 20;
  localparam int PHASE_W           = 3;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 16;

  typedef logic [PHASE_W-1:0] phase_t;

  localparam phase_t PH_WAIT = 3'd0;
  localparam phase_t PH_UP   = 3'd1;
  localparam phase_t PH_HOLD = 3'd2;
  localparam phase_t PH_DOWN = 3'd3;
  localparam phase_t PH_DONE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd3;

  typedef struct packed {
    logic [TICK_W-1:0] delay_ticks;
    logic [TICK_W-1:0] scroll_ticks;
    logic [LEN_W-1:0]  scroll_length;
    logic              profile_mode;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [TICK_W-1:0] elapsed;
  } item_t;

endpackage

>>> src/mso_front.sv
// ----------------------------------------------------------------------------
// mso_front
// Classifies a time into its profile phase and the ticks elapsed in its ramp.
// ----------------------------------------------------------------------------
module mso_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mso_pkg::cfg_t                 cfg,
  input  logic                          accept,
  input  logic [mso_pkg::TIME_W-1:0]    current_time,
  output logic                          item_valid,
  output mso_pkg::item_t                item
);
  import mso_pkg::*;

  logic           valid_r;
  item_t          item_r;
  item_t          item_nxt;
  logic [TIME_W:0] t;
  logic [TIME_W:0] d;
  logic [TIME_W:0] s;
  logic [TIME_W:0] ds;
  logic [TIME_W:0] dds;
  logic [TIME_W:0] ddss;
  logic [TIME_W:0] diff;

  always_comb begin
    t    = {1'b0, current_time};
    d    = (TIME_W+1)'(cfg.delay_ticks);
    s    = (TIME_W+1)'(cfg.scroll_ticks);
    ds   = d + s;
    dds  = ds + d;
    ddss = dds + s;
    diff = '0;
    item_nxt.phase = PH_DONE;
    if (t < d) begin
      item_nxt.phase = PH_WAIT;
    end else if (t < ds) begin
      item_nxt.phase = PH_UP;
      diff = t - d;
    end else if (cfg.profile_mode) begin
      item_nxt.phase = PH_DONE;
    end else if (t < dds) begin
      item_nxt.phase = PH_HOLD;
    end else if (t < ddss) begin
      item_nxt.phase = PH_DOWN;
      diff = t - dds;
    end
    item_nxt.elapsed = diff[TICK_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> src/mso_queue.sv
// ----------------------------------------------------------------------------
// mso_queue
// Two-entry item queue between the classifier and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module mso_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mso_pkg::item_t push_item,
  input  logic           pop,
  output logic           not_empty,
  output logic           full,
  output mso_pkg::item_t head
);
  import mso_pkg::*;

  item_t      mem_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       do_pop;

  assign do_pop    = pop && (cnt_r != 2'd0);
  assign not_empty = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign head      = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) cnt_nxt = cnt_r + 2'd1;
    if (!push && do_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (do_pop) rd_r <= ~rd_r;
    end
    if (push) mem_r[wr_r] <= push_item;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(full && push && !pop)) else $error("queue overflow");
`endif

endmodule

>>> src/mso_back.sv
// ----------------------------------------------------------------------------
// mso_back
// Pipelined ramp fraction divider, smootherstep easing and offset scaling.
// ----------------------------------------------------------------------------
module mso_back #(
  parameter int FRACTION_BITS = mso_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mso_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  input  mso_pkg::item_t                 in_item,
  output logic                           out_strobe,
  output logic [mso_pkg::OFS_W-1:0]      out_offset,
  output logic [mso_pkg::PHASE_W-1:0]    out_phase
);
  import mso_pkg::*;

  localparam int F  = FRACTION_BITS;
  localparam int AW = F + 4;
  localparam int PW = OFS_W + F + 1;

  logic [TICK_W-1:0] rem_r [F+1];
  logic [F-1:0]      q_r   [F+1];
  phase_t            dph_r [F+1];
  logic              dv_r  [F+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else begin
      dv_r[0] <= in_valid;
    end
    rem_r[0] <= in_item.elapsed;
    q_r[0]   <= '0;
    dph_r[0] <= in_item.phase;
  end

  genvar k;
  generate
    for (k = 0; k < F; k++) begin : g_div
      logic [TICK_W:0]   sh;
      logic [TICK_W:0]   sub;
      logic              ge;
      assign sh  = {rem_r[k], 1'b0};
      assign sub = sh - {1'b0, cfg.scroll_ticks};
      assign ge  = (sh >= {1'b0, cfg.scroll_ticks});
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_r[k+1] <= 1'b0;
        end else begin
          dv_r[k+1] <= dv_r[k];
        end
        rem_r[k+1] <= ge ? sub[TICK_W-1:0] : sh[TICK_W-1:0];
        q_r[k+1]   <= {q_r[k][F-2:0], ge};
        dph_r[k+1] <= dph_r[k];
      end
    end
  endgenerate

  logic [F-1:0]    f;
  logic [AW-1:0]   a;
  assign f = q_r[F];
  assign a = (AW'(15) << F) - (AW'(f) * AW'(6));

  logic [F+AW-1:0] s1_fa_r;
  logic [2*F-1:0]  s1_ff_r;
  logic [F-1:0]    s1_f_r;
  phase_t          s1_ph_r;
  logic            s1_v_r;

  logic [AW-1:0]   inner;
  logic [F-1:0]    f2;
  assign inner = (AW'(10) << F) - s1_fa_r[F+AW-1:F];
  assign f2    = s1_ff_r[2*F-1:F];

  logic [AW-1:0]   s2_inner_r;
  logic [2*F-1:0]  s2_f3p_r;
  logic [F-1:0]    s2_f_r;
  phase_t          s2_ph_r;
  logic            s2_v_r;

  logic [F-1:0]    f3;
  assign f3 = s2_f3p_r[2*F-1:F];

  logic [F+AW-1:0] s3_ep_r;
  logic [F-1:0]    s3_f_r;
  phase_t          s3_ph_r;
  logic            s3_v_r;

  logic [AW-1:0]   e_raw;
  logic [F:0]      e;
  logic [F:0]      mul_op;
  logic [OFS_W-1:0] l8;
  assign e_raw  = s3_ep_r[F+AW-1:F];
  assign e      = (e_raw > (AW'(1) << F)) ? ((F+1)'(1) << F) : e_raw[F:0];
  assign mul_op = cfg.profile_mode ? {1'b0, s3_f_r} : e;
  assign l8     = {cfg.scroll_length, 8'd0};

  logic [PW-1:0]   s4_prod_r;
  phase_t          s4_ph_r;
  logic            s4_v_r;

  logic [OFS_W-1:0] scaled;
  logic [OFS_W-1:0] ofs_nxt;
  assign scaled = s4_prod_r[OFS_W+F-1:F];

  always_comb begin
    case (s4_ph_r)
      PH_UP:   ofs_nxt = scaled;
      PH_HOLD: ofs_nxt = l8;
      PH_DOWN: ofs_nxt = l8 - scaled;
      default: ofs_nxt = '0;
    endcase
  end

  logic [OFS_W-1:0] ofs_r;
  phase_t           oph_r;
  logic             ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      s1_v_r <= dv_r[F];
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      ov_r   <= s4_v_r;
    end
    s1_fa_r    <= (F+AW)'(f) * (F+AW)'(a);
    s1_ff_r    <= (2*F)'(f) * (2*F)'(f);
    s1_f_r     <= f;
    s1_ph_r    <= dph_r[F];
    s2_inner_r <= inner;
    s2_f3p_r   <= (2*F)'(f2) * (2*F)'(s1_f_r);
    s2_f_r     <= s1_f_r;
    s2_ph_r    <= s1_ph_r;
    s3_ep_r    <= (F+AW)'(f3) * (F+AW)'(s2_inner_r);
    s3_f_r     <= s2_f_r;
    s3_ph_r    <= s2_ph_r;
    s4_prod_r  <= PW'(l8) * PW'(mul_op);
    s4_ph_r    <= s3_ph_r;
    ofs_r      <= ofs_nxt;
    oph_r      <= s4_ph_r;
  end

  assign out_strobe = ov_r;
  assign out_offset = ofs_r;
  assign out_phase  = oph_r;

`ifndef SYNTHESIS
  a_rest_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && (oph_r == PH_WAIT || oph_r == PH_DONE)) |-> (ofs_r == '0))
    else $error("offset not zero at rest");
  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oph_r == PH_HOLD) |-> (ofs_r == l8))
    else $error("hold offset not full length");
  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (ofs_r <= l8)) else $error("offset beyond length");
`endif

endmodule

>>> src/marquee_scroll_offset.sv
// ----------------------------------------------------------------------------
// marquee_scroll_offset
// Scroll offset profile for a text marquee, bounce with eased ramps or loop.
// ----------------------------------------------------------------------------
// Usage: write delay, duration, length and mode on the cfg_ channel (index,
// data, valid/ready; ready is always high) while no item is in flight.
// Present a time on in_current_time with start high; it is taken when busy is
// low. Each item gives one result: out_offset (Q12.8 pixels) and out_phase,
// shown for one cycle with out_strobe high. The receiver cannot stall.
// Pipeline: FRACTION_BITS + 8 register stages, the first loaded at the
// accepting edge: one classify stage, one queue stage, one divider input
// stage, one divider stage per fraction bit, four easing and scaling stages
// and the output stage.
// Throughput: one item per cycle; the divider and multipliers are fully
// pipelined, so busy stays low in normal use.
// Reset: registers return to delay 0, duration 1, length 0, bounce mode,
// and the pipeline is emptied.
// ----------------------------------------------------------------------------
module marquee_scroll_offset #(
  parameter int FRACTION_BITS = mso_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [mso_pkg::TIME_W-1:0]        in_current_time,
  output logic                              out_strobe,
  output logic [mso_pkg::OFS_W-1:0]         out_offset,
  output logic [mso_pkg::PHASE_W-1:0]       out_phase,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mso_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mso_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mso_pkg::*;

  cfg_t  cfg_r;
  logic  accept;
  logic  f_valid;
  item_t f_item;
  logic  q_ne;
  logic  q_full;
  item_t q_head;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_ticks   <= '0;
      cfg_r.scroll_ticks  <= TICK_W'(1);
      cfg_r.scroll_length <= '0;
      cfg_r.profile_mode  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DELAY:  cfg_r.delay_ticks   <= cfg_data;
        REG_SCROLL: cfg_r.scroll_ticks  <= cfg_data;
        REG_LENGTH: cfg_r.scroll_length <= cfg_data[LEN_W-1:0];
        REG_MODE:   cfg_r.profile_mode  <= cfg_data[0];
        default:    cfg_r               <= cfg_r;
      endcase
    end
  end

  mso_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .accept       (accept),
    .current_time (in_current_time),
    .item_valid   (f_valid),
    .item         (f_item)
  );

  mso_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_item (f_item),
    .pop       (1'b1),
    .not_empty (q_ne),
    .full      (q_full),
    .head      (q_head)
  );

  mso_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (q_ne),
    .in_item    (q_head),
    .out_strobe (out_strobe),
    .out_offset (out_offset),
    .out_phase  (out_phase)
  );

endmodule
